FILE: src/binary_grid_neighbor_count_filter_core_macros.svh
// assertion macros shared by the checker
`ifndef BINARY_GRID_NEIGHBOR_COUNT_FILTER_CORE_MACROS_SVH
`define BINARY_GRID_NEIGHBOR_COUNT_FILTER_CORE_MACROS_SVH

// property checked on every edge outside reset
`define BGNC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bgnc check failed");

// property checked on every edge, reset included
`define BGNC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bgnc check failed");

`endif

FILE: src/bgnc_pkg.sv
package bgnc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int TARGET_W   = 3;
	localparam int CNT_W      = 3;
	localparam int RESET_DIM  = 256;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS         = 3'd0,
		REG_COLUMNS      = 3'd1,
		REG_FILL_MODE    = 3'd2,
		REG_TARGET_COUNT = 3'd3,
		REG_RESTORE_KEEP = 3'd4
	} cfg_reg_t;

	// one line buffer entry per column: last two rows of cell bits, marks of the newer row
	typedef struct packed {
		logic newer;
		logic older;
		logic keep;
		logic cutout;
	} line_entry_t;

endpackage

FILE: src/bgnc_line_buf.sv
module bgnc_line_buf
	import bgnc_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic        clk,
	input  logic        en,
	input  logic [AW-1:0] wr_addr,
	input  line_entry_t wr_data,
	input  logic [AW-1:0] rd_addr,
	output line_entry_t rd_data
);

	line_entry_t mem [DEPTH];
	line_entry_t rd_q;

	// write current column, read ahead the next one; same address forwards the new entry
	always_ff @(posedge clk) begin
		if (en) begin
			mem[wr_addr] <= wr_data;
			if (rd_addr == wr_addr) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

FILE: src/binary_grid_neighbor_count_filter_core.sv
// channel   handshake                  payload
// cell      cell_valid / cell_stall    cell_filled keep_cell cut_mark pad_item
// result    res_valid / res_stall      result_filled last_cell
// config    cfg_valid / cfg_ready      cfg_index cfg_data
//
// one cell per clock unless stalled; results follow the cell below via s1 and the output reg
// a single column-indexed line buffer (one write, one read per cycle) holds the rows
// results trail their cells by one row, a row of pad items flushes the last one
// arst_n resets control and configuration; buffer contents are never read stale
// the cell side stalls only while the output register is held and the stage before it is full
module binary_grid_neighbor_count_filter_core
	import bgnc_pkg::*;
#(
	parameter int MAX_ROWS    = 256,
	parameter int MAX_COLUMNS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cell_valid,
	output logic                  cell_stall,
	input  logic                  cell_filled,
	input  logic                  keep_cell,
	input  logic                  cut_mark,
	input  logic                  pad_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  result_filled,
	output logic                  last_cell,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int CNW = $clog2(MAX_COLUMNS + 1);
	localparam int AW  = $clog2(MAX_COLUMNS);
	localparam int RESET_ROWS = (RESET_DIM > MAX_ROWS) ? MAX_ROWS : RESET_DIM;
	localparam int RESET_COLS = (RESET_DIM > MAX_COLUMNS) ? MAX_COLUMNS : RESET_DIM;

	// configuration
	logic [RW-1:0]       rows_q;
	logic [CNW-1:0]      columns_q;
	logic                fill_mode_q;
	logic [TARGET_W-1:0] target_q;
	logic                restore_q;

	// raster position of the next cell
	logic [RW-1:0] in_row_q;
	logic [AW-1:0] in_col_q;
	logic          left_q;

	// neighbourhood stage
	logic          valid_s1;
	logic          cur_s1;
	logic          up_s1;
	logic          down_s1;
	logic          left_s1;
	logic          right_en_s1;
	logic          keep_s1;
	logic          cut_s1;
	logic          last_s1;

	// output register
	logic          res_valid_q;
	logic          result_q;
	logic          last_q;

	logic          cfg_wr;
	logic [RW-1:0]  rows_wr;
	logic [CNW-1:0] cols_wr;
	logic          cell_xfer;
	logic          flushing;
	logic          live;
	logic          step;
	logic          emit;
	logic          col_last;
	logic          last_pos;
	logic [AW-1:0] next_col;
	logic          bit_in;
	line_entry_t   wr_entry;
	line_entry_t   ahead;
	logic          s1_adv;
	logic          right_nb;
	logic [CNT_W-1:0] cnt;
	logic          res_s1;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// clamp geometry writes to 1..max
	always_comb begin
		if (cfg_data == '0) begin
			rows_wr = RW'(1);
		end else if (32'(cfg_data) > 32'(MAX_ROWS)) begin
			rows_wr = RW'(MAX_ROWS);
		end else begin
			rows_wr = RW'(cfg_data);
		end
		if (cfg_data == '0) begin
			cols_wr = CNW'(1);
		end else if (32'(cfg_data) > 32'(MAX_COLUMNS)) begin
			cols_wr = CNW'(MAX_COLUMNS);
		end else begin
			cols_wr = CNW'(cfg_data);
		end
	end

	// cell decode and raster bookkeeping
	assign s1_adv     = !res_valid_q || !res_stall;
	assign cell_stall = valid_s1 && !s1_adv;
	assign cell_xfer  = cell_valid && !cell_stall;
	assign flushing   = in_row_q >= rows_q;
	assign live       = !pad_item && !flushing;
	assign step       = cell_xfer && !(pad_item && !flushing);
	assign emit       = in_row_q != '0;
	assign col_last   = (CNW'(in_col_q) + CNW'(1)) >= columns_q;
	assign next_col   = col_last ? '0 : in_col_q + AW'(1);
	assign last_pos   = (in_row_q == rows_q) && col_last;
	assign bit_in     = cell_filled && live;

	always_comb begin
		wr_entry.newer  = bit_in;
		wr_entry.older  = ahead.newer;
		wr_entry.keep   = keep_cell && live;
		wr_entry.cutout = cut_mark && live;
	end

	bgnc_line_buf #(
		.DEPTH (MAX_COLUMNS),
		.AW    (AW)
	) u_line_buf (
		.clk     (clk),
		.en      (step),
		.wr_addr (in_col_q),
		.wr_data (wr_entry),
		.rd_addr (next_col),
		.rd_data (ahead)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= RW'(RESET_ROWS);
			columns_q   <= CNW'(RESET_COLS);
			fill_mode_q <= 1'b0;
			target_q    <= '0;
			restore_q   <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROWS:         rows_q      <= rows_wr;
				REG_COLUMNS:      columns_q   <= cols_wr;
				REG_FILL_MODE:    fill_mode_q <= cfg_data[0];
				REG_TARGET_COUNT: target_q    <= cfg_data[TARGET_W-1:0];
				REG_RESTORE_KEEP: restore_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// position counters; geometry writes and the last cell restart the grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (cfg_wr && (cfg_reg_t'(cfg_index) == REG_ROWS ||
				cfg_reg_t'(cfg_index) == REG_COLUMNS)) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (step) begin
			if (emit && last_pos) begin
				in_row_q <= '0;
				in_col_q <= '0;
			end else begin
				in_col_q <= next_col;
				if (col_last) begin
					in_row_q <= in_row_q + RW'(1);
				end
			end
		end
	end

	// left neighbour is the centre of the previous column
	always_ff @(posedge clk) begin
		if (step) begin
			left_q <= ahead.newer;
		end
	end

	// neighbourhood stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (step) begin
			valid_s1 <= emit;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// neighbourhood stage payload, borders masked here
	always_ff @(posedge clk) begin
		if (step) begin
			cur_s1      <= ahead.newer;
			up_s1       <= ahead.older && (in_row_q >= RW'(2));
			down_s1     <= bit_in && (in_row_q < rows_q);
			left_s1     <= left_q && (in_col_q != '0);
			right_en_s1 <= !col_last;
			keep_s1     <= ahead.keep;
			cut_s1      <= ahead.cutout;
			last_s1     <= last_pos;
		end
	end

	// right neighbour comes from the read-ahead entry registered at the transfer
	assign right_nb = ahead.newer && right_en_s1;

	always_comb begin
		cnt = CNT_W'(up_s1) + CNT_W'(down_s1) + CNT_W'(left_s1) + CNT_W'(right_nb);
		res_s1 = cur_s1;
		if (!fill_mode_q) begin
			if (cur_s1 && cnt == target_q) begin
				res_s1 = 1'b0;
			end
			if (restore_q && keep_s1) begin
				res_s1 = 1'b1;
			end
		end else begin
			if (!cur_s1 && cnt == target_q) begin
				res_s1 = 1'b1;
			end
			if (cut_s1) begin
				res_s1 = 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			result_q <= res_s1;
			last_q   <= last_s1;
		end
	end

	assign res_valid     = res_valid_q;
	assign result_filled = result_q;
	assign last_cell     = last_q;

endmodule

FILE: src/bgnc_checker.sv
`include "binary_grid_neighbor_count_filter_core_macros.svh"

module bgnc_checker (
	input logic clk,
	input logic arst_n,
	input logic cell_valid,
	input logic cell_stall,
	input logic res_valid,
	input logic res_stall,
	input logic result_filled,
	input logic last_cell
);

	// a held result stays offered
	`BGNC_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid)

	// a held result keeps its payload
	`BGNC_ASSERT(a_res_stable, res_valid && res_stall |=> $stable(result_filled) && $stable(last_cell))

	// nothing is offered while in reset
	`BGNC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !res_valid)

	// a fresh result follows a cell transfer through the neighbourhood stage and the output register
	`BGNC_ASSERT(a_res_latency, $rose(res_valid) |-> $past(cell_valid && !cell_stall, 2))

endmodule

bind binary_grid_neighbor_count_filter_core bgnc_checker u_bgnc_checker (.*);
